@@ design/cbm_pkg.sv @@
// Shared types, operation codes and register map for the cartridge bank mapper.
// Used by cbm_state, cbm_xlate and the top level cartridge_bank_mapper_with_cycle_irq.
// No dependencies.
package cbm_pkg;

	typedef enum logic [2:0] {
		OP_POWER_ON = 3'd0,
		OP_REG_WRITE = 3'd1,
		OP_TICK = 3'd2,
		OP_PROG_XLATE = 3'd3,
		OP_CHAR_XLATE = 3'd4
	} op_t;

	typedef logic [7:0] bank_t;
	typedef bank_t [7:0] char_banks_t;
	typedef bank_t [2:0] prog_banks_t;

	typedef struct packed {
		logic [2:0] op;
		logic [15:0] address;
		logic [7:0] write_data;
		logic [7:0] elapsed_cycles;
	} item_t;

	typedef struct packed {
		logic irq_pending;
		logic irq_enable;
		logic mirror_bit;
	} status_t;

	localparam logic [15:0] REG_MASK = 16'hF007;
	localparam logic [15:0] REG_CHAR_BASE = 16'hB000;
	localparam logic [15:0] REG_PROG0 = 16'h8000;
	localparam logic [15:0] REG_PROG1 = 16'hA000;
	localparam logic [15:0] REG_PROG2 = 16'hC000;
	localparam logic [15:0] REG_MIRROR = 16'h9001;
	localparam logic [15:0] REG_IRQ_CTRL = 16'h9003;
	localparam logic [15:0] REG_IRQ_LOAD = 16'h9004;
	localparam logic [15:0] REG_RELOAD_HI = 16'h9005;
	localparam logic [15:0] REG_RELOAD_LO = 16'h9006;

	localparam logic [15:0] PROG_BASE = 16'h8000;
	localparam bank_t PROG_LAST_BANK = 8'hFF;
	localparam logic [15:0] COUNTER_WRAP = 16'hFFFF;
	localparam int unsigned OUT_WIDTH = 21;

	localparam prog_banks_t PROG_RESET = {8'hFE, 8'h01, 8'h00};

	function automatic char_banks_t char_reset();
		char_banks_t banks;
		for (int i = 0; i < 8; i++) begin
			banks[i] = 8'(i);
		end
		return banks;
	endfunction

endpackage

@@ design/cbm_state.sv @@
// Mapper state: bank registers, mirroring bit and the cycle IRQ counter.
// Computes the next state for one item and commits it when the item is applied.
// Depends on cbm_pkg.
module cbm_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 apply,
	input  cbm_pkg::item_t       item,
	input  logic                 cart_mirror,
	output cbm_pkg::char_banks_t char_bank,
	output cbm_pkg::prog_banks_t prog_bank,
	output cbm_pkg::status_t     cur,
	output cbm_pkg::status_t     nxt
);

	cbm_pkg::char_banks_t char_bank_q, char_bank_d;
	cbm_pkg::prog_banks_t prog_bank_q, prog_bank_d;
	logic mirror_q, mirror_d;
	logic enable_q, enable_d;
	logic pending_q, pending_d;
	logic [15:0] counter_q, counter_d;
	logic [15:0] reload_q, reload_d;
	logic [15:0] masked;
	logic [16:0] diff;

	always_comb begin
		char_bank_d = char_bank_q;
		prog_bank_d = prog_bank_q;
		mirror_d = mirror_q;
		enable_d = enable_q;
		pending_d = pending_q;
		counter_d = counter_q;
		reload_d = reload_q;
		masked = item.address & cbm_pkg::REG_MASK;
		diff = {1'b0, counter_q} - {9'd0, item.elapsed_cycles};
		unique case (item.op)
			cbm_pkg::OP_POWER_ON: begin
				char_bank_d = cbm_pkg::char_reset();
				prog_bank_d = cbm_pkg::PROG_RESET;
				mirror_d = ~cart_mirror;
			end
			cbm_pkg::OP_REG_WRITE: begin
				if (masked[15:3] == cbm_pkg::REG_CHAR_BASE[15:3]) begin
					char_bank_d[masked[2:0]] = item.write_data;
				end else begin
					unique case (masked)
						cbm_pkg::REG_PROG0: prog_bank_d[0] = item.write_data;
						cbm_pkg::REG_PROG1: prog_bank_d[1] = item.write_data;
						cbm_pkg::REG_PROG2: prog_bank_d[2] = item.write_data;
						cbm_pkg::REG_MIRROR: mirror_d = item.write_data[7];
						cbm_pkg::REG_IRQ_CTRL: begin
							enable_d = item.write_data[7];
							pending_d = 1'b0;
						end
						cbm_pkg::REG_IRQ_LOAD: counter_d = reload_q;
						cbm_pkg::REG_RELOAD_HI: reload_d = {item.write_data, reload_q[7:0]};
						cbm_pkg::REG_RELOAD_LO: reload_d = {reload_q[15:8], item.write_data};
						default: ;
					endcase
				end
			end
			cbm_pkg::OP_TICK: begin
				if (enable_q) begin
					if (diff[16]) begin
						pending_d = 1'b1;
						enable_d = 1'b0;
						counter_d = cbm_pkg::COUNTER_WRAP;
					end else begin
						counter_d = diff[15:0];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_bank_q <= cbm_pkg::char_reset();
			prog_bank_q <= cbm_pkg::PROG_RESET;
			mirror_q <= 1'b1;
			enable_q <= 1'b0;
			pending_q <= 1'b0;
			counter_q <= '0;
			reload_q <= '0;
		end else if (apply) begin
			char_bank_q <= char_bank_d;
			prog_bank_q <= prog_bank_d;
			mirror_q <= mirror_d;
			enable_q <= enable_d;
			pending_q <= pending_d;
			counter_q <= counter_d;
			reload_q <= reload_d;
		end
	end

	assign char_bank = char_bank_q;
	assign prog_bank = prog_bank_q;
	assign cur = '{irq_pending: pending_q, irq_enable: enable_q, mirror_bit: mirror_q};
	assign nxt = '{irq_pending: pending_d, irq_enable: enable_d, mirror_bit: mirror_d};

endmodule

@@ design/cbm_xlate.sv @@
// Program and character address translation through the current bank registers.
// Gives zero for operations that are not translations and for addresses out of range.
// Depends on cbm_pkg.
module cbm_xlate (
	input  cbm_pkg::item_t       item,
	input  cbm_pkg::char_banks_t char_bank,
	input  cbm_pkg::prog_banks_t prog_bank,
	output logic [cbm_pkg::OUT_WIDTH-1:0] mapped_address
);

	cbm_pkg::bank_t prog_sel;

	always_comb begin
		prog_sel = (item.address[14:13] == 2'd3) ? cbm_pkg::PROG_LAST_BANK
			: prog_bank[item.address[14:13]];
		mapped_address = '0;
		unique case (item.op)
			cbm_pkg::OP_PROG_XLATE: begin
				if (item.address >= cbm_pkg::PROG_BASE) begin
					mapped_address = {prog_sel, item.address[12:0]};
				end
			end
			cbm_pkg::OP_CHAR_XLATE: begin
				if (item.address[15:13] == 3'd0) begin
					mapped_address = {3'd0, char_bank[item.address[12:10]],
						item.address[9:0]};
				end
			end
			default: ;
		endcase
	end

endmodule

@@ design/cartridge_bank_mapper_with_cycle_irq.sv @@
// Top level of the cartridge bank mapper with a cycle-counting IRQ.
// Holds the input and result registers and instantiates cbm_state and cbm_xlate.
// Depends on cbm_pkg, cbm_state and cbm_xlate.
//
// Channel  Dir  Handshake             Content
// s_*      in   s_tvalid / s_tready   tuser: operation; tdata: address, write_data, cycles
// m_*      out  m_tvalid / m_tready   tdata: mapped_address, irq_line, mirror_select
// cfg_*    in   cfg_valid / cfg_ready cart_mirror bit
//
// One item is accepted per cycle while the result register is not stalled.
// An item is held in the input register, then state update and translation
// are done in one pass into the result register.
// A stalled result holds the input register; the input side stays ready while the
// input register is empty or moves on. Reset returns all mapper state to its reset values at once.
module cartridge_bank_mapper_with_cycle_irq (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // address[15:0], write_data[23:16], elapsed_cycles[31:24]
	input  logic [2:0]  s_tuser,  // operation[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // mapped_address[20:0], irq_line[21], mirror_select[22]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	logic s1_valid;
	cbm_pkg::item_t item_s1;
	logic advance;
	logic cart_mirror_q;
	logic m_valid_q;
	logic [23:0] m_data_q;
	cbm_pkg::char_banks_t char_bank;
	cbm_pkg::prog_banks_t prog_bank;
	cbm_pkg::status_t cur;
	cbm_pkg::status_t nxt;
	logic [cbm_pkg::OUT_WIDTH-1:0] mapped;

	assign advance = s1_valid && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_mirror_q <= 1'b0;
		end else if (cfg_valid) begin
			cart_mirror_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= '{op: s_tuser, address: s_tdata[15:0],
				write_data: s_tdata[23:16], elapsed_cycles: s_tdata[31:24]};
		end
	end

	cbm_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.apply      (advance),
		.item       (item_s1),
		.cart_mirror(cart_mirror_q),
		.char_bank  (char_bank),
		.prog_bank  (prog_bank),
		.cur        (cur),
		.nxt        (nxt)
	);

	cbm_xlate u_xlate (
		.item          (item_s1),
		.char_bank     (char_bank),
		.prog_bank     (prog_bank),
		.mapped_address(mapped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {1'b0, ~nxt.mirror_bit, nxt.irq_pending, mapped};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.op != cbm_pkg::OP_PROG_XLATE
			&& item_s1.op != cbm_pkg::OP_CHAR_XLATE |=> m_tdata[20:0] == '0)
		else $error("non-translate item produced a nonzero address");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cur.irq_pending) |-> $past(advance && item_s1.op == cbm_pkg::OP_TICK))
		else $error("IRQ raised by something other than a tick");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cur.irq_pending) |-> !cur.irq_enable)
		else $error("IRQ raised without clearing the enable");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tdata[21] == cur.irq_pending && m_tdata[22] == !cur.mirror_bit)
		else $error("result status does not match the committed state");

endmodule

@@ dv/tb_cartridge_bank_mapper_with_cycle_irq.sv @@
// Self-checking testbench for cartridge_bank_mapper_with_cycle_irq: a directed table of
// bus items followed by random phases, each result compared with a table reply or an in-bench predictor.
// Depends on cbm_pkg and the cartridge_bank_mapper_with_cycle_irq RTL.
module tb_cartridge_bank_mapper_with_cycle_irq;

	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;
	localparam logic [15:0] CHAR_SPAN = 16'h2000;
	localparam int QUIET_LIMIT = 2000;
	localparam int NUM_DIRECTED = 32;
	localparam int NUM_PHASES = 6;
	localparam int PHASE_ITEMS = 230;

	typedef struct packed {
		logic [20:0] mapped;
		logic irq;
		logic mirror_sel;
	} reply_t;

	typedef struct packed {
		logic [2:0] op;
		logic [15:0] addr;
		logic [7:0] data;
		logic [7:0] cycles;
		logic typed;
		reply_t reply;
	} bus_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic [2:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	cbm_pkg::char_banks_t chr_banks;
	cbm_pkg::prog_banks_t prg_banks;
	logic cart_mirror_cfg;
	logic mirror_q;
	logic irq_en;
	logic irq_flag;
	logic [15:0] irq_count;
	logic [15:0] irq_latch;

	reply_t replies_due[$];
	bus_row_t bus_items[$];
	int mismatch_count;
	int quiet_cycles;
	int stall_mode;
	int stall_timer;
	logic [15:0] stall_pattern;
	logic [3:0] stall_phase;

	bus_row_t directed_rows [NUM_DIRECTED] = '{
		'{cbm_pkg::OP_PROG_XLATE, 16'h8000, 8'h00, 8'h00, 1'b1, '{21'h000000, 1'b0, 1'b0}},
		'{cbm_pkg::OP_PROG_XLATE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, '{21'h1FFFFF, 1'b0, 1'b0}},
		'{cbm_pkg::OP_PROG_XLATE, 16'h7FFF, 8'h00, 8'h00, 1'b1, '{21'h000000, 1'b0, 1'b0}},
		'{cbm_pkg::OP_PROG_XLATE, 16'hC123, 8'h00, 8'h00, 1'b1, '{21'h1FC123, 1'b0, 1'b0}},
		'{cbm_pkg::OP_PROG_XLATE, 16'hA000, 8'h00, 8'h00, 1'b1, '{21'h002000, 1'b0, 1'b0}},
		'{cbm_pkg::OP_CHAR_XLATE, 16'h0000, 8'h00, 8'h00, 1'b1, '{21'h000000, 1'b0, 1'b0}},
		'{cbm_pkg::OP_CHAR_XLATE, 16'h1FFF, 8'h00, 8'h00, 1'b1, '{21'h001FFF, 1'b0, 1'b0}},
		'{cbm_pkg::OP_CHAR_XLATE, 16'h2000, 8'h00, 8'h00, 1'b1, '{21'h000000, 1'b0, 1'b0}},
		'{cbm_pkg::OP_CHAR_XLATE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, '{21'h000000, 1'b0, 1'b0}},
		'{OP_SPARE_FIRST, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, '{21'h000000, 1'b0, 1'b0}},
		'{OP_SPARE_LAST, 16'h8000, 8'h80, 8'h01, 1'b1, '{21'h000000, 1'b0, 1'b0}},
		'{cbm_pkg::OP_TICK, 16'h0000, 8'h00, 8'hFF, 1'b1, '{21'h000000, 1'b0, 1'b0}},
		'{cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_PROG0, 8'hFF, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_PROG_XLATE, 16'h9FFF, 8'h00, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_REG_WRITE, 16'hBFFF, 8'hFF, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_CHAR_XLATE, 16'h1C00, 8'h00, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_REG_WRITE, 16'h9FF9, 8'h7F, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_RELOAD_HI, 8'h00, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_RELOAD_LO, 8'h02, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_IRQ_LOAD, 8'h00, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_IRQ_CTRL, 8'h80, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_TICK, 16'h0000, 8'h00, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_TICK, 16'h0000, 8'h00, 8'h02, 1'b0, '0},
		'{cbm_pkg::OP_TICK, 16'h0000, 8'h00, 8'h01, 1'b0, '0},
		'{cbm_pkg::OP_TICK, 16'h0000, 8'h00, 8'hFF, 1'b0, '0},
		'{cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_IRQ_CTRL, 8'h7F, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_REG_WRITE, 16'h9000, 8'hFF, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_REG_WRITE, 16'hE007, 8'hFF, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_PROG1, 8'h80, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_PROG2, 8'h00, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_PROG_XLATE, 16'hDFFF, 8'h00, 8'h00, 1'b0, '0},
		'{cbm_pkg::OP_POWER_ON, 16'hFFFF, 8'hFF, 8'hFF, 1'b0, '0}
	};

	cartridge_bank_mapper_with_cycle_irq dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void load_power_on_banks();
		for (int i = 0; i < 8; i++) begin
			chr_banks[i] = 8'(i);
		end
		prg_banks[0] = 8'h00;
		prg_banks[1] = 8'h01;
		prg_banks[2] = 8'hFE;
		mirror_q = ~cart_mirror_cfg;
	endfunction

	function automatic reply_t mapper_step(input cbm_pkg::item_t it);
		reply_t r;
		logic [15:0] reg_addr;
		logic [15:0] remaining;
		logic [1:0] window;
		cbm_pkg::bank_t bank;
		r = '0;
		case (it.op)
			cbm_pkg::OP_POWER_ON: load_power_on_banks();
			cbm_pkg::OP_REG_WRITE: begin
				reg_addr = it.address & cbm_pkg::REG_MASK;
				if (reg_addr >= cbm_pkg::REG_CHAR_BASE &&
						reg_addr <= (cbm_pkg::REG_CHAR_BASE | 16'h0007)) begin
					chr_banks[reg_addr[2:0]] = it.write_data;
				end else begin
					case (reg_addr)
						cbm_pkg::REG_PROG0: prg_banks[0] = it.write_data;
						cbm_pkg::REG_PROG1: prg_banks[1] = it.write_data;
						cbm_pkg::REG_PROG2: prg_banks[2] = it.write_data;
						cbm_pkg::REG_MIRROR: mirror_q = it.write_data[7];
						cbm_pkg::REG_IRQ_CTRL: begin
							irq_en = it.write_data[7];
							irq_flag = 1'b0;
						end
						cbm_pkg::REG_IRQ_LOAD: irq_count = irq_latch;
						cbm_pkg::REG_RELOAD_HI: irq_latch[15:8] = it.write_data;
						cbm_pkg::REG_RELOAD_LO: irq_latch[7:0] = it.write_data;
						default: ;
					endcase
				end
			end
			cbm_pkg::OP_TICK: begin
				if (irq_en) begin
					remaining = irq_count - 16'(it.elapsed_cycles);
					if (remaining > irq_count) begin
						irq_flag = 1'b1;
						irq_en = 1'b0;
						irq_count = cbm_pkg::COUNTER_WRAP;
					end else begin
						irq_count = remaining;
					end
				end
			end
			cbm_pkg::OP_PROG_XLATE: begin
				if (it.address >= cbm_pkg::PROG_BASE) begin
					window = 2'((it.address - cbm_pkg::PROG_BASE) >> 13);
					bank = (window < 2'd3) ? prg_banks[window] : cbm_pkg::PROG_LAST_BANK;
					r.mapped = {bank, it.address[12:0]};
				end
			end
			cbm_pkg::OP_CHAR_XLATE: begin
				if (it.address < CHAR_SPAN) begin
					r.mapped = 21'({chr_banks[it.address[12:10]], it.address[9:0]});
				end
			end
			default: ;
		endcase
		r.irq = irq_flag;
		r.mirror_sel = ~mirror_q;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [20:0] got,
			input logic [20:0] want);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
		end
	endtask

	task automatic add_item(input logic [2:0] op, input logic [15:0] addr,
			input logic [7:0] data, input logic [7:0] cycles);
		bus_row_t row;
		row = '{op, addr, data, cycles, 1'b0, '0};
		bus_items.push_back(row);
	endtask

	function automatic logic [15:0] pick_register();
		logic [15:0] spread;
		spread = 16'($urandom) & ~cbm_pkg::REG_MASK;
		case ($urandom_range(0, 10))
			0: return cbm_pkg::REG_PROG0 | spread;
			1: return cbm_pkg::REG_PROG1 | spread;
			2: return cbm_pkg::REG_PROG2 | spread;
			3: return cbm_pkg::REG_CHAR_BASE | spread | 16'($urandom_range(0, 7));
			4: return cbm_pkg::REG_MIRROR | spread;
			5: return cbm_pkg::REG_IRQ_CTRL | spread;
			6: return cbm_pkg::REG_IRQ_LOAD | spread;
			7: return cbm_pkg::REG_RELOAD_HI | spread;
			8: return cbm_pkg::REG_RELOAD_LO | spread;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_random_item();
		int pick;
		logic [7:0] data;
		logic [7:0] cycles;
		pick = $urandom_range(0, 99);
		data = 8'($urandom);
		cycles = 8'($urandom);
		if (pick < 3) begin
			add_item(cbm_pkg::OP_POWER_ON, 16'($urandom), data, cycles);
		end else if (pick < 40) begin
			add_item(cbm_pkg::OP_REG_WRITE, pick_register(), data, cycles);
		end else if (pick < 62) begin
			add_item(cbm_pkg::OP_TICK, 16'($urandom), data, cycles);
		end else if (pick < 80) begin
			add_item(cbm_pkg::OP_PROG_XLATE, 16'($urandom), data, cycles);
		end else if (pick < 97) begin
			add_item(cbm_pkg::OP_CHAR_XLATE, ($urandom_range(0, 4) == 0) ? 16'($urandom) :
				16'($urandom_range(0, 16'h1FFF)), data, cycles);
		end else begin
			add_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), 16'($urandom),
				data, cycles);
		end
	endtask

	// Arming sequences mostly load a small count so that the following ticks can reach the wrap.
	task automatic build_phase(input int count);
		int ticks;
		while (bus_items.size() < count) begin
			if ($urandom_range(0, 7) == 0) begin
				add_item(cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_RELOAD_HI,
					($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00, 8'($urandom));
				add_item(cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_RELOAD_LO, 8'($urandom),
					8'($urandom));
				add_item(cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_IRQ_LOAD, 8'($urandom),
					8'($urandom));
				add_item(cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_IRQ_CTRL,
					8'h80 | 8'($urandom_range(0, 127)), 8'($urandom));
				ticks = $urandom_range(1, 10);
				for (int k = 0; k < ticks; k++) begin
					add_item(cbm_pkg::OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
				end
				if ($urandom_range(0, 1) == 0) begin
					add_item(cbm_pkg::OP_REG_WRITE, cbm_pkg::REG_IRQ_CTRL, 8'($urandom),
						8'($urandom));
				end
			end else begin
				add_random_item();
			end
		end
	endtask

	task automatic send_items();
		bus_row_t row;
		cbm_pkg::item_t it;
		reply_t predicted;
		int burst;
		int gap;
		while (bus_items.size() > 0) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && bus_items.size() > 0; k++) begin
				row = bus_items.pop_front();
				s_tuser <= row.op;
				s_tdata <= {row.cycles, row.data, row.addr};
				s_tvalid <= 1'b1;
				do @(posedge clk); while (!s_tready);
				it = '{row.op, row.addr, row.data, row.cycles};
				predicted = mapper_step(it);
				replies_due.push_back(row.typed ? row.reply : predicted);
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0 || bus_items.size() == 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		while (replies_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cart_mirror(input logic value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cart_mirror_cfg = value;
	endtask

	always @(posedge clk) begin
		if (stall_timer == 0) begin
			stall_timer <= $urandom_range(50, 300);
			stall_mode <= $urandom_range(0, 2);
			stall_pattern <= (stall_mode == 1) ? 16'($urandom & $urandom) | 16'h0001 :
				16'($urandom) | 16'h0001;
		end else begin
			stall_timer <= stall_timer - 1;
		end
		stall_phase <= stall_phase + 4'd1;
		m_tready <= (stall_mode == 0) ? 1'b1 : stall_pattern[stall_phase];
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (replies_due.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[20:0], '0);
			end else begin
				want = replies_due.pop_front();
				if (m_tdata[20:0] !== want.mapped) begin
					report_mismatch("mapped_address", m_tdata[20:0], want.mapped);
				end
				if (m_tdata[21] !== want.irq) begin
					report_mismatch("irq_line", 21'(m_tdata[21]), 21'(want.irq));
				end
				if (m_tdata[22] !== want.mirror_sel) begin
					report_mismatch("mirror_select", 21'(m_tdata[22]), 21'(want.mirror_sel));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("cartridge_bank_mapper_with_cycle_irq test failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		stall_mode = 0;
		stall_timer = 0;
		stall_pattern = 16'hFFFF;
		stall_phase = '0;
		quiet_cycles = 0;
		mismatch_count = 0;
		cart_mirror_cfg = 1'b0;
		load_power_on_banks();
		irq_en = 1'b0;
		irq_flag = 1'b0;
		irq_count = '0;
		irq_latch = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_cart_mirror(1'b0);
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			bus_items.push_back(directed_rows[i]);
		end
		send_items();

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			write_cart_mirror((p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom));
			if ($urandom_range(0, 3) != 0) begin
				add_item(cbm_pkg::OP_POWER_ON, 16'($urandom), 8'($urandom), 8'($urandom));
			end
			build_phase(PHASE_ITEMS);
			send_items();
		end

		wait_drained();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0 && replies_due.size() == 0) begin
			$display("cartridge_bank_mapper_with_cycle_irq test passed");
		end else begin
			$display("cartridge_bank_mapper_with_cycle_irq test failed");
		end
		$finish;
	end

endmodule
